// ----- src/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg - shared definitions for the byte ring FIFO
// Field widths, command codes, register map and sizing helpers.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int LANES_DEF  = 8;
    localparam int LANES_MAX  = 8;

    localparam int CMD_W      = 2;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int CAP_W      = 11;
    localparam int CAP_MIN    = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam int PADDR_W    = 1;
    localparam int PDATA_W    = 32;
    localparam logic [PADDR_W-1:0] REG_CAPACITY = 1'b0;

    localparam int BYTE_IDX_W = $clog2(LANES_MAX);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ROOM  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                  is_read;
        logic [LEN_W-1:0]      done_len;
        logic [BYTE_IDX_W-1:0] start_bank;
    } meta_t;

    function automatic int pow2_at_least(input int n, input int floor_val);
        int p;
        begin
            p = floor_val;
            while (p < n)
            begin
                p = p * 2;
            end
            return p;
        end
    endfunction

    // power-of-two bank count, at least two so a bank index always has a bit
    function automatic int bank_count(input int lanes);
        begin
            return pow2_at_least(lanes, 2);
        end
    endfunction

endpackage

// ----- src/brf_req_if.sv -----
// ----------------------------------------------------------------------------
// brf_req_if - command channel
// Valid/ready channel carrying one request: command, length, write bytes.
// ----------------------------------------------------------------------------
interface brf_req_if;
    import brf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, cmd, len, write_data, input ready);
    modport sink   (input valid, cmd, len, write_data, output ready);

endinterface

// ----- src/brf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// brf_rsp_if - result channel
// Valid/ready channel carrying one result: done length, read bytes, fill.
// ----------------------------------------------------------------------------
interface brf_rsp_if #(
    parameter int FILL_W = brf_pkg::CAP_W
);
    import brf_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  done_len;
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, done_len, read_data, fill_level, input ready);
    modport sink   (input valid, done_len, read_data, fill_level, output ready);

endinterface

// ----- src/brf_ram.sv -----
// ----------------------------------------------------------------------------
// brf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl - pointer, count and register control
// Capacity register, command decode, pointer/count update, bank addressing.
// ----------------------------------------------------------------------------
module brf_ctrl #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF,
    parameter int LANES = brf_pkg::LANES_DEF,
    parameter int BANKS = brf_pkg::bank_count(LANES),
    parameter int ROWS  = brf_pkg::pow2_at_least((DEPTH + BANKS - 1) / BANKS, 2),
    parameter int CNT_W = brf_pkg::CAP_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brf_pkg::PADDR_W-1:0]         paddr,
    input  logic [brf_pkg::PDATA_W-1:0]         pwdata,
    output logic [brf_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                accept,
    input  logic [brf_pkg::CMD_W-1:0]           cmd,
    input  logic [brf_pkg::LEN_W-1:0]           len,
    input  logic [brf_pkg::DATA_W-1:0]          write_data,
    output logic [BANKS-1:0]                    wr_en,
    output logic [BANKS-1:0][$clog2(ROWS)-1:0]  wr_row,
    output logic [BANKS-1:0][7:0]               wr_byte,
    output logic [BANKS-1:0][$clog2(ROWS)-1:0]  rd_row,
    output brf_pkg::meta_t                      meta_next,
    output logic [CNT_W-1:0]                    fill_next
);
    import brf_pkg::*;

    localparam int BB    = $clog2(BANKS);
    localparam int RW    = $clog2(ROWS);
    localparam int PTR_W = BB + RW;
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int CW    = (DW > CAP_W) ? DW : CAP_W;
    localparam int CAP_EFF_RST = (int'(CAP_RESET) > DEPTH) ? DEPTH : int'(CAP_RESET);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] cap_eff_reg, cap_eff_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] held_reg, held_next;

    logic             cfg_wr;
    logic [CW-1:0]    cap_in;
    logic [CW-1:0]    cap_clamp;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] len_cnt;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] drop;
    logic             len_ok;
    logic             wr_ok;
    logic             rd_ok;
    logic             room_ok;
    logic             clr;
    logic [BB-1:0]    wp_bank;
    logic [BB-1:0]    rp_bank;
    logic [RW-1:0]    wp_row;
    logic [RW-1:0]    rp_row;
    logic [BB-1:0]    lane [BANKS];
    logic [7:0]       wbytes [LANES_MAX];

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_comb
    begin
        cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);
        cap_in = CW'(pwdata[CAP_W-1:0]);
        if (cap_in < CW'(CAP_MIN))
        begin
            cap_clamp = CW'(CAP_MIN);
        end
        else if (cap_in > CW'(DEPTH))
        begin
            cap_clamp = CW'(DEPTH);
        end
        else
        begin
            cap_clamp = cap_in;
        end
        cap_next     = cfg_wr ? pwdata[CAP_W-1:0] : cap_reg;
        cap_eff_next = cfg_wr ? CNT_W'(cap_clamp) : cap_eff_reg;
    end

    always_comb
    begin
        free_cnt = (held_reg <= cap_eff_reg) ? cap_eff_reg - held_reg : '0;
        len_cnt  = CNT_W'(len);
        len_ok   = (len != '0) && (len <= LEN_W'(LANES));
        wr_ok    = accept && (cmd == CMD_WRITE) && len_ok && (len_cnt <= free_cnt);
        rd_ok    = accept && (cmd == CMD_READ) && len_ok && (len_cnt <= held_reg);
        room_ok  = accept && (cmd == CMD_ROOM) && len_ok && (len_cnt > free_cnt);
        clr      = accept && (cmd == CMD_CLEAR);
        need     = len_cnt - free_cnt;
        drop     = (need > held_reg) ? held_reg : need;
    end

    always_comb
    begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        held_next = held_reg;
        if (cfg_wr || clr)
        begin
            rp_next   = '0;
            wp_next   = '0;
            held_next = '0;
        end
        else if (wr_ok)
        begin
            wp_next   = wp_reg + PTR_W'(len);
            held_next = held_reg + len_cnt;
        end
        else if (rd_ok)
        begin
            rp_next   = rp_reg + PTR_W'(len);
            held_next = held_reg - len_cnt;
        end
        else if (room_ok)
        begin
            rp_next   = rp_reg + PTR_W'(drop);
            held_next = held_reg - drop;
        end
    end

    assign fill_next            = held_next;
    assign meta_next.is_read    = rd_ok;
    assign meta_next.done_len   = (wr_ok || rd_ok) ? len : '0;
    assign meta_next.start_bank = BYTE_IDX_W'(rp_reg[BB-1:0]);

    // byte at ring position p sits in bank p mod BANKS, row p / BANKS
    always_comb
    begin
        wp_bank = wp_reg[BB-1:0];
        wp_row  = wp_reg[PTR_W-1:BB];
        rp_bank = rp_reg[BB-1:0];
        rp_row  = rp_reg[PTR_W-1:BB];
        for (int j = 0; j < LANES_MAX; j++)
        begin
            wbytes[j] = write_data[8*j +: 8];
        end
        for (int b = 0; b < BANKS; b++)
        begin
            lane[b]    = BB'(b) - wp_bank;
            wr_en[b]   = wr_ok && (LEN_W'(lane[b]) < len);
            wr_byte[b] = wbytes[BYTE_IDX_W'(lane[b])];
            wr_row[b]  = (BB'(b) < wp_bank) ? wp_row + RW'(1) : wp_row;
            rd_row[b]  = (BB'(b) < rp_bank) ? rp_row + RW'(1) : rp_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            cap_eff_reg <= CNT_W'(CAP_EFF_RST);
            rp_reg      <= '0;
            wp_reg      <= '0;
            held_reg    <= '0;
        end
        else
        begin
            cap_reg     <= cap_next;
            cap_eff_reg <= cap_eff_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            held_reg    <= held_next;
        end
    end

endmodule

// ----- src/brf_align.sv -----
// ----------------------------------------------------------------------------
// brf_align - read alignment and result register
// Rotates bank read data into stream order, masks it, holds the result.
// ----------------------------------------------------------------------------
module brf_align #(
    parameter int BANKS = 8,
    parameter int CNT_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    output logic                        in_ready,
    input  brf_pkg::meta_t              meta_next,
    input  logic [CNT_W-1:0]            fill_next,
    input  logic [BANKS-1:0][7:0]       rd_byte,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [brf_pkg::LEN_W-1:0]   done_len,
    output logic [brf_pkg::DATA_W-1:0]  read_data,
    output logic [CNT_W-1:0]            fill_level
);
    import brf_pkg::*;

    localparam int BB = $clog2(BANKS);

    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    meta_t             meta_reg;
    logic [CNT_W-1:0]  fill_s1_reg;
    logic [LEN_W-1:0]  done_reg;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic [CNT_W-1:0]  fill_reg;
    logic              s1_move;
    logic [BB-1:0]     bsel [LANES_MAX];

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // oldest byte comes from the bank at the read pointer
    always_comb
    begin
        for (int i = 0; i < LANES_MAX; i++)
        begin
            bsel[i] = meta_reg.start_bank[BB-1:0] + BB'(i);
            if (meta_reg.is_read && (LEN_W'(i) < meta_reg.done_len))
            begin
                rdata_next[8*i +: 8] = rd_byte[bsel[i]];
            end
            else
            begin
                rdata_next[8*i +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg    <= meta_next;
            fill_s1_reg <= fill_next;
        end
        if (s1_move)
        begin
            done_reg  <= meta_reg.done_len;
            rdata_reg <= rdata_next;
            fill_reg  <= fill_s1_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign done_len   = done_reg;
    assign read_data  = rdata_reg;
    assign fill_level = fill_reg;

endmodule

// ----- src/byte_ring_fifo_atomic.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_atomic - byte ring FIFO with all-or-nothing commands
// Write, read, make-room and clear on a banked byte store, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                           Handshake
// request  in   cmd, len, write_data              valid / ready
// result   out  done_len, read_data, fill_level   valid / ready
// apb      in   capacity register at 0x0          psel / penable, pready = 1
//
// One command accepted per cycle while the result is not stalled; its result
// passes through the bank RAM read register, then the result register.
// Bytes are spread over power-of-two banks, so up to eight move per cycle.
// Reset clears pointers and count and sets capacity to 1024; store contents are kept.
// A stalled result holds; one more command waits in the RAM read stage.
// ----------------------------------------------------------------------------
module byte_ring_fifo_atomic #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF,
    parameter int LANES = brf_pkg::LANES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brf_pkg::PADDR_W-1:0] paddr,
    input  logic [brf_pkg::PDATA_W-1:0] pwdata,
    output logic [brf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    brf_req_if.sink                     request,
    brf_rsp_if.source                   result
);
    import brf_pkg::*;

    localparam int BANKS = bank_count(LANES);
    localparam int ROWS  = pow2_at_least((DEPTH + BANKS - 1) / BANKS, 2);
    localparam int RW    = $clog2(ROWS);
    localparam int CNT_W = CAP_W;

    logic                       accept;
    logic                       in_ready;
    logic [BANKS-1:0]           wr_en;
    logic [BANKS-1:0][RW-1:0]   wr_row;
    logic [BANKS-1:0][7:0]      wr_byte;
    logic [BANKS-1:0][RW-1:0]   rd_row;
    logic [BANKS-1:0][7:0]      rd_byte;
    meta_t                      meta_next;
    logic [CNT_W-1:0]           fill_next;

    assign accept        = request.valid && in_ready;
    assign request.ready = in_ready;

    brf_ctrl #(
        .DEPTH (DEPTH),
        .LANES (LANES),
        .BANKS (BANKS),
        .ROWS  (ROWS),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .accept     (accept),
        .cmd        (request.cmd),
        .len        (request.len),
        .write_data (request.write_data),
        .wr_en      (wr_en),
        .wr_row     (wr_row),
        .wr_byte    (wr_byte),
        .rd_row     (rd_row),
        .meta_next  (meta_next),
        .fill_next  (fill_next)
    );

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        brf_ram #(
            .WIDTH (8),
            .WORDS (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en[b]),
            .waddr (wr_row[b]),
            .wdata (wr_byte[b]),
            .re    (accept),
            .raddr (rd_row[b]),
            .rdata (rd_byte[b])
        );
    end

    brf_align #(
        .BANKS (BANKS),
        .CNT_W (CNT_W)
    ) u_align (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_ready   (in_ready),
        .meta_next  (meta_next),
        .fill_next  (fill_next),
        .rd_byte    (rd_byte),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .done_len   (result.done_len),
        .read_data  (result.read_data),
        .fill_level (result.fill_level)
    );

endmodule

// ----- src/brf_checker.sv -----
// ----------------------------------------------------------------------------
// brf_checker - port-level checks for the byte ring FIFO
// Result channel behavior over time, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF,
    parameter int LANES = brf_pkg::LANES_DEF,
    parameter int CNT_W = brf_pkg::CAP_W
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [brf_pkg::LEN_W-1:0]   done_len,
    input logic [brf_pkg::DATA_W-1:0]  read_data,
    input logic [CNT_W-1:0]            fill_level
);
    import brf_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(done_len)
            && $stable(read_data) && $stable(fill_level))
        else $error("result changed while stalled");

    a_done_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> done_len <= LEN_W'(LANES))
        else $error("done_len above lane count");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (read_data >> {done_len, 3'b000}) == '0)
        else $error("read_data has bytes beyond done_len");

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> int'(fill_level) <= DEPTH)
        else $error("fill_level above depth");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind byte_ring_fifo_atomic brf_checker #(
    .DEPTH (DEPTH),
    .LANES (LANES)
) u_brf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .done_len   (result.done_len),
    .read_data  (result.read_data),
    .fill_level (result.fill_level)
);
